@@ sv/bdt_pkg.sv @@
`default_nettype none

package bdt_pkg;

  // Depth of the sample window per button
  localparam int unsigned HISTORY_DEPTH = 8;

  // Field widths
  localparam int unsigned BTN_W     = 2;
  localparam int unsigned TIMEOUT_W = 24;

  // Countdown value after reset
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(12000);

  // Button bit positions
  localparam int unsigned BTN_REQ = 0;
  localparam int unsigned BTN_EMG = 1;

  // Event codes
  typedef enum logic [1:0] {
    KIND_REQUEST = 2'd0,
    KIND_EMG_ON  = 2'd1,
    KIND_EMG_OFF = 2'd2
  } kind_t;

  typedef logic [BTN_W-1:0]     btn_t;
  typedef logic [TIMEOUT_W-1:0] timeout_t;

endpackage

`default_nettype wire

@@ sv/bdt_if.sv @@
`default_nettype none

// Sampled button tick
interface bdt_in_if import bdt_pkg::*; ();
  logic valid;
  logic ready;
  btn_t button_sample;

  modport source (output valid, output button_sample, input ready);
  modport sink   (input valid, input button_sample, output ready);
endinterface

// Event request
interface bdt_out_if import bdt_pkg::*; ();
  logic  valid;
  logic  ready;
  kind_t event_kind;
  logic  by_timeout;
  btn_t  debounced_state;

  modport source (output valid, output event_kind, output by_timeout,
                  output debounced_state, input ready);
  modport sink   (input valid, input event_kind, input by_timeout,
                  input debounced_state, output ready);
endinterface

// Timeout register write
interface bdt_cfg_if import bdt_pkg::*; ();
  logic     valid;
  logic     ready;
  timeout_t timeout_ticks;

  modport source (output valid, output timeout_ticks, input ready);
  modport sink   (input valid, input timeout_ticks, output ready);
endinterface

`default_nettype wire

@@ sv/bdt_debounce.sv @@
`default_nettype none

module bdt_debounce import bdt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic load,
  input  wire btn_t sample,
  output btn_t      deb_r,
  output btn_t      deb_nxt
);

  btn_t hist_r   [HISTORY_DEPTH];
  btn_t hist_nxt [HISTORY_DEPTH];
  btn_t all_ones;
  btn_t any_one;

  // Shift the new sample into the window
  always_comb begin
    hist_nxt[0] = sample;
    for (int i = 1; i < HISTORY_DEPTH; i++) begin
      hist_nxt[i] = hist_r[i-1];
    end
  end

  // Reduce the window: all pressed sets, all released clears
  always_comb begin
    all_ones = '1;
    any_one  = '0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      all_ones = all_ones & hist_nxt[i];
      any_one  = any_one | hist_nxt[i];
    end
    deb_nxt = (deb_r | all_ones) & any_one;
  end

  // Advance window and debounced levels on each tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
      deb_r <= '0;
    end else if (load) begin
      hist_r <= hist_nxt;
      deb_r  <= deb_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/button_debounce_with_timeout.sv @@
`default_nettype none

// Two-button debouncer with an idle timeout. Each accepted tick carries two
// raw button levels (bit 0 request, bit 1 emergency); a debounced level
// changes only when the last eight samples all agree. A request is raised on
// a debounced press of button 0 or when the idle countdown reaches zero, and
// the countdown then reloads from timeout_ticks. Otherwise a debounced press
// of button 1 toggles the emergency flag and reports on or released. Ticks
// without an event produce no output. One tick is taken every clock cycle;
// the result appears in the output register in the cycle after acceptance, and
// input is held off only while that register is full and not being taken.
// Writing timeout_ticks also reloads the countdown; write it only when idle.
module button_debounce_with_timeout import bdt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  bdt_in_if.sink    in_chan,
  bdt_out_if.source out_chan,
  bdt_cfg_if.sink   cfg_chan
);

  timeout_t timeout_r;
  timeout_t cnt_r;
  timeout_t cnt_dec;
  logic     emg_r;
  logic     accept;
  logic     timed_out;
  logic     req_evt;
  logic     emg_evt;
  btn_t     deb_r;
  btn_t     deb_nxt;
  btn_t     rising;

  logic  out_valid_r;
  kind_t kind_r;
  logic  by_timeout_r;
  btn_t  state_r;

  assign in_chan.ready  = !out_valid_r || out_chan.ready;
  assign cfg_chan.ready = 1'b1;
  assign accept         = in_chan.valid && in_chan.ready;

  bdt_debounce u_debounce (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (accept),
    .sample  (in_chan.button_sample),
    .deb_r   (deb_r),
    .deb_nxt (deb_nxt)
  );

  // Decide the event for this tick
  always_comb begin
    cnt_dec   = (cnt_r == '0) ? '0 : cnt_r - TIMEOUT_W'(1);
    timed_out = (cnt_dec == '0);
    rising    = deb_nxt & ~deb_r;
    req_evt   = rising[BTN_REQ] || timed_out;
    emg_evt   = !req_evt && rising[BTN_EMG];
  end

  // Hold timeout register, countdown and emergency flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
      cnt_r     <= TIMEOUT_RESET;
      emg_r     <= 1'b0;
    end else if (cfg_chan.valid) begin
      timeout_r <= cfg_chan.timeout_ticks;
      cnt_r     <= cfg_chan.timeout_ticks;
    end else if (accept) begin
      cnt_r <= req_evt ? timeout_r : cnt_dec;
      if (emg_evt) begin
        emg_r <= !emg_r;
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= req_evt || emg_evt;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      if (req_evt) begin
        kind_r <= KIND_REQUEST;
      end else if (emg_r) begin
        kind_r <= KIND_EMG_OFF;
      end else begin
        kind_r <= KIND_EMG_ON;
      end
      by_timeout_r <= req_evt && timed_out;
      state_r      <= deb_nxt;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.event_kind      = kind_r;
  assign out_chan.by_timeout      = by_timeout_r;
  assign out_chan.debounced_state = state_r;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import bdt_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int PRESSURE_HOLD  = 60;
  localparam int SETTLE_CYCLES  = 4;

  typedef struct packed {
    kind_t kind;
    bit    by_timeout;
    btn_t  levels;
  } btn_event_t;

  // What the sender promised for one tick: typed rows carry their own answer
  typedef struct packed {
    bit         typed;
    bit         fires;
    btn_event_t evt;
  } tick_note_t;

  typedef struct {
    btn_t       btn;
    int         reps;
    bit         typed;
    bit         fires;
    btn_event_t evt;
  } press_row_t;

  logic clk;
  logic rst_n;

  bdt_in_if  in_chan ();
  bdt_out_if out_chan ();
  bdt_cfg_if cfg_chan ();

  button_debounce_with_timeout i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // Debouncer state mirrored by the predictor
  btn_t     win_hist [HISTORY_DEPTH];
  int       win_slot;
  btn_t     deb_levels;
  timeout_t idle_count;
  timeout_t reload_ticks;
  bit       emg_on;

  tick_note_t  tick_notes [$];
  btn_event_t  pending_events [$];
  int          fail_count;
  int          cycle_count;
  bit          idle_on;
  bit          pressure_go;

  // Directed presses: the last tick of each typed run carries the typed answer
  press_row_t press_table [4] = '{
    '{2'b11, 8, 1'b1, 1'b1, '{KIND_REQUEST, 1'b0, 2'b11}},
    '{2'b00, 8, 1'b1, 1'b0, '{KIND_REQUEST, 1'b0, 2'b00}},
    '{2'b10, 8, 1'b1, 1'b1, '{KIND_EMG_ON,  1'b0, 2'b10}},
    '{2'b01, 1, 1'b0, 1'b0, '{KIND_REQUEST, 1'b0, 2'b00}}
  };

  // Advance the debouncer by one tick; return 1 when an event is raised
  function automatic bit debounce_tick(input btn_t btn, output btn_event_t evt);
    btn_t all_ones;
    btn_t any_one;
    btn_t prev;
    btn_t rising;
    bit   timed_out;
    all_ones = '1;
    any_one  = '0;
    evt      = '{KIND_REQUEST, 1'b0, 2'b00};
    if (idle_count != 0) idle_count = idle_count - 1'b1;
    prev = deb_levels;
    win_hist[win_slot] = btn;
    win_slot = (win_slot + 1 >= HISTORY_DEPTH) ? 0 : win_slot + 1;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      all_ones &= win_hist[i];
      any_one  |= win_hist[i];
    end
    deb_levels = (deb_levels | all_ones) & any_one;
    rising = deb_levels & ~prev;
    timed_out = (idle_count == 0);
    if (rising[BTN_REQ] || timed_out) begin
      evt = '{KIND_REQUEST, timed_out, deb_levels};
      idle_count = reload_ticks;
      return 1'b1;
    end
    if (rising[BTN_EMG]) begin
      emg_on = ~emg_on;
      evt = '{emg_on ? KIND_EMG_ON : KIND_EMG_OFF, 1'b0, deb_levels};
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[button_debounce_with_timeout] ERROR");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (pressure_go) begin
        pressure_go = 1'b0;
        hold_left   = PRESSURE_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_chan.ready = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        out_chan.ready = 1'b0;
      end else begin
        out_chan.ready = 1'b1;
      end
    end
  end

  // Track writes, accepted ticks and delivered requests
  always @(posedge clk) begin
    tick_note_t note;
    btn_event_t evt;
    btn_event_t want;
    bit         fires;
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        if (pending_events.size() == 0) begin
          $error("unexpected request: kind %0d, by_timeout %0d, levels %0d",
                 out_chan.event_kind, out_chan.by_timeout, out_chan.debounced_state);
          fail_count++;
        end else begin
          want = pending_events.pop_front();
          if (out_chan.event_kind !== want.kind) begin
            $error("event_kind: expected %0d, actual %0d", want.kind, out_chan.event_kind);
            fail_count++;
          end
          if (out_chan.by_timeout !== want.by_timeout) begin
            $error("by_timeout: expected %0d, actual %0d", want.by_timeout,
                   out_chan.by_timeout);
            fail_count++;
          end
          if (out_chan.debounced_state !== want.levels) begin
            $error("debounced_state: expected %0d, actual %0d", want.levels,
                   out_chan.debounced_state);
            fail_count++;
          end
        end
      end
      if (cfg_chan.valid && cfg_chan.ready) begin
        reload_ticks = cfg_chan.timeout_ticks;
        idle_count   = cfg_chan.timeout_ticks;
      end
      if (in_chan.valid && in_chan.ready) begin
        note  = tick_notes.pop_front();
        fires = debounce_tick(in_chan.button_sample, evt);
        if (note.typed) begin
          if (note.fires) pending_events.push_back(note.evt);
        end else if (fires) begin
          pending_events.push_back(evt);
        end
      end
    end
  end

  // Offer one tick and hold it until taken
  task automatic send_tick(input btn_t btn, input bit typed, input bit fires,
                           input btn_event_t evt);
    tick_notes.push_back('{typed, fires, evt});
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_chan.valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_chan.valid         = 1'b1;
    in_chan.button_sample = btn;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  // Drop valid and wait until every request has been delivered
  task automatic drain();
    in_chan.valid = 1'b0;
    while (tick_notes.size() != 0 || pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_timeout(input timeout_t ticks);
    cfg_chan.valid         = 1'b1;
    cfg_chan.timeout_ticks = ticks;
    do @(posedge clk); while (!cfg_chan.ready);
    @(negedge clk);
    cfg_chan.valid = 1'b0;
  endtask

  // Held presses with random length and bounce, some pure noise
  task automatic run_presses(input int count);
    btn_t target;
    btn_t btn;
    int   run_left;
    target   = '0;
    run_left = 0;
    for (int n = 0; n < count; n++) begin
      if (run_left == 0) begin
        target   = btn_t'($urandom_range(0, 3));
        run_left = $urandom_range(1, 24);
      end
      run_left--;
      btn = target;
      if ($urandom_range(0, 9) == 0) btn = btn_t'($urandom_range(0, 3));
      else if ($urandom_range(0, 5) == 0) btn ^= btn_t'($urandom_range(1, 3));
      send_tick(btn, 1'b0, 1'b0, '{KIND_REQUEST, 1'b0, 2'b00});
    end
  endtask

  initial begin
    timeout_t phase_ticks [6];
    int       phase_items [6];
    bit       last_tick;
    in_chan.valid          = 1'b0;
    in_chan.button_sample  = '0;
    cfg_chan.valid         = 1'b0;
    cfg_chan.timeout_ticks = '0;
    rst_n       = 1'b0;
    idle_on     = 1'b1;
    pressure_go = 1'b0;
    fail_count  = 0;
    cycle_count = 0;
    foreach (win_hist[i]) win_hist[i] = '0;
    win_slot     = 0;
    deb_levels   = '0;
    emg_on       = 1'b0;
    reload_ticks = TIMEOUT_RESET;
    idle_count   = TIMEOUT_RESET;

    phase_ticks = '{24'd1, 24'hFFFFFF, 24'd0, timeout_t'($urandom_range(2, 30)),
                    timeout_t'($urandom_range(9, 150)), TIMEOUT_RESET};
    phase_items = '{140, 140, 40, 140, 140, 140};

    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed presses with the reset timeout
    foreach (press_table[r]) begin
      for (int k = 0; k < press_table[r].reps; k++) begin
        last_tick = (k == press_table[r].reps - 1);
        send_tick(press_table[r].btn, press_table[r].typed,
                  last_tick && press_table[r].fires, press_table[r].evt);
      end
    end
    drain();

    // Random presses under several timeout settings; the last runs flat out
    for (int p = 0; p < 6; p++) begin
      write_timeout(phase_ticks[p]);
      idle_on = (p != 5);
      if (p == 0) pressure_go = 1'b1;
      run_presses(phase_items[p]);
      drain();
    end

    if (fail_count == 0) begin
      $display("[button_debounce_with_timeout] OK");
    end else begin
      $display("[button_debounce_with_timeout] ERROR");
    end
    $finish;
  end

endmodule
